// ----- hdl/rau_pkg.sv -----
`timescale 1ns / 1ps

package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_W             = 33;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_INC = 3'd4,
        OP_DEC = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        MSEL_X,
        MSEL_Y,
        MSEL_Z
    } msel_t;

    typedef struct packed {
        logic  capture;
        logic  mul_en;
        msel_t mul_sel;
        logic  gcd_init;
        logic  gcd_step;
        logic  div_init;
        logic  div_step;
        logic  res_load;
        logic  res_quot;
    } cmd_t;

    typedef struct packed {
        logic is_mul;
        logic gcd_zero;
        logic gcd_done;
        logic div_done;
    } status_t;

endpackage

// ----- hdl/rau_if.sv -----
`timescale 1ns / 1ps

interface rau_in_if #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [2:0]                      op;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (
        output valid,
        output op,
        output a_num,
        output a_den,
        output b_num,
        output b_den,
        input  ready
    );

    modport sink (
        input  valid,
        input  op,
        input  a_num,
        input  a_den,
        input  b_num,
        input  b_den,
        output ready
    );
endinterface

interface rau_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [rau_pkg::RES_W-1:0] res_num;
    logic signed [rau_pkg::RES_W-1:0] res_den;
    logic                            zero_den;

    modport source (
        output valid,
        output res_num,
        output res_den,
        output zero_den,
        input  ready
    );

    modport sink (
        input  valid,
        input  res_num,
        input  res_den,
        input  zero_den,
        output ready
    );
endinterface

// ----- hdl/rational_arithmetic_unit.sv -----
// Steps: capture on an input transfer, three products in S_MUL0 to S_MUL2,
// S_CHECK, then S_FINISH loads the result for add, subtract, divide, increment
// and decrement; multiply with a nonzero product adds the binary GCD loop and
// a restoring divider before S_FINISH. Only one item is in the unit at a time.
// A finished result waits in the output register while the next item is taken.
// Reset is asynchronous, active low, and leaves the unit idle with no result.
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    rau_in_if.sink   operands,
    rau_out_if.source result
);

    rau_pkg::cmd_t    cmd;
    rau_pkg::status_t status;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .op       (operands.op),
        .a_num    (operands.a_num),
        .a_den    (operands.a_den),
        .b_num    (operands.b_num),
        .b_den    (operands.b_den),
        .res_num  (result.res_num),
        .res_den  (result.res_den),
        .zero_den (result.zero_den)
    );

endmodule

// ----- hdl/rau_ctrl.sv -----
`timescale 1ns / 1ps

module rau_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output rau_pkg::cmd_t    cmd,
    input  rau_pkg::status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_CHECK,
        S_GCD,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   sel_quot_reg;
    logic   sel_quot_next;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = rau_pkg::MSEL_X;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sel_quot_next  = sel_quot_reg;
        in_ready       = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture   = 1'b1;
                    sel_quot_next = 1'b0;
                    state_next    = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MSEL_X;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MSEL_Y;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rau_pkg::MSEL_Z;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.is_mul && !status.gcd_zero)
                begin
                    cmd.gcd_init  = 1'b1;
                    sel_quot_next = 1'b1;
                    state_next    = S_GCD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_quot   = sel_quot_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sel_quot_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sel_quot_reg  <= sel_quot_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_second_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("A second transfer was accepted while an item was in progress.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(out_valid_reg && !out_ready))
        else $error("A pending result was overwritten.");

    a_quot_only_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_quot_reg && state_reg != S_IDLE) |-> status.is_mul)
        else $error("Reduced result selected for an operation other than multiply.");

endmodule

// ----- hdl/rau_datapath.sv -----
`timescale 1ns / 1ps

module rau_datapath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rau_pkg::cmd_t                     cmd,
    output rau_pkg::status_t                  status,
    input  logic [2:0]                        op,
    input  logic signed [OPERAND_WIDTH-1:0]   a_num,
    input  logic signed [OPERAND_WIDTH-1:0]   a_den,
    input  logic signed [OPERAND_WIDTH-1:0]   b_num,
    input  logic signed [OPERAND_WIDTH-1:0]   b_den,
    output logic signed [rau_pkg::RES_W-1:0]  res_num,
    output logic signed [rau_pkg::RES_W-1:0]  res_den,
    output logic                              zero_den
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int XW = (PW + 1 > rau_pkg::RES_W) ? PW + 1 : rau_pkg::RES_W;
    localparam int CW = $clog2(PW + 1);

    logic [2:0]                       op_reg;
    logic signed [W-1:0]              an_reg;
    logic signed [W-1:0]              ad_reg;
    logic signed [W-1:0]              bn_reg;
    logic signed [W-1:0]              bd_reg;
    logic signed [PW-1:0]             x_reg;
    logic signed [PW-1:0]             y_reg;
    logic signed [PW-1:0]             z_reg;
    logic [PW-1:0]                    u_reg;
    logic [PW-1:0]                    v_reg;
    logic [PW-1:0]                    m1_reg;
    logic [PW-1:0]                    m2_reg;
    logic [PW-1:0]                    rem1_reg;
    logic [PW-1:0]                    rem2_reg;
    logic [CW-1:0]                    cnt_reg;
    logic signed [rau_pkg::RES_W-1:0] res_num_reg;
    logic signed [rau_pkg::RES_W-1:0] res_den_reg;
    logic                             zero_den_reg;

    logic                             is_mul;
    logic signed [W-1:0]              mul_a;
    logic signed [W-1:0]              mul_b;
    logic signed [PW-1:0]             prod;
    logic [PW-1:0]                    x_mag;
    logic [PW-1:0]                    y_mag;
    logic [PW:0]                      t1;
    logic [PW:0]                      t2;
    logic [PW:0]                      d1;
    logic [PW:0]                      d2;
    logic                             ge1;
    logic                             ge2;
    logic signed [XW-1:0]             xe;
    logic signed [XW-1:0]             ye;
    logic signed [XW-1:0]             ze;
    logic signed [XW-1:0]             ane;
    logic signed [XW-1:0]             ade;
    logic signed [XW-1:0]             q1e;
    logic signed [XW-1:0]             q2e;
    logic signed [XW-1:0]             rn_x;
    logic signed [XW-1:0]             rd_x;

    assign is_mul = (op_reg == rau_pkg::OP_MUL);

    always_comb
    begin
        mul_a = ad_reg;
        mul_b = bd_reg;
        case (cmd.mul_sel)
            rau_pkg::MSEL_X:
            begin
                mul_a = an_reg;
                mul_b = is_mul ? bn_reg : bd_reg;
            end
            rau_pkg::MSEL_Y:
            begin
                mul_a = ad_reg;
                mul_b = is_mul ? bd_reg : bn_reg;
            end
            rau_pkg::MSEL_Z:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign prod  = PW'(mul_a) * PW'(mul_b);
    assign x_mag = x_reg[PW-1] ? ((~x_reg) + PW'(1)) : x_reg;
    assign y_mag = y_reg[PW-1] ? ((~y_reg) + PW'(1)) : y_reg;

    assign t1  = {rem1_reg, m1_reg[PW-1]};
    assign t2  = {rem2_reg, m2_reg[PW-1]};
    assign ge1 = (t1 >= {1'b0, u_reg});
    assign ge2 = (t2 >= {1'b0, u_reg});
    assign d1  = t1 - {1'b0, u_reg};
    assign d2  = t2 - {1'b0, u_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op;
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                rau_pkg::MSEL_X: x_reg <= prod;
                rau_pkg::MSEL_Y: y_reg <= prod;
                rau_pkg::MSEL_Z: z_reg <= prod;
                default:         z_reg <= prod;
            endcase
        end
        if (cmd.gcd_init)
        begin
            u_reg  <= x_mag;
            v_reg  <= y_mag;
            m1_reg <= x_mag;
            m2_reg <= y_mag;
        end
        else if (cmd.gcd_step)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg  <= u_reg >> 1;
                v_reg  <= v_reg >> 1;
                m1_reg <= m1_reg >> 1;
                m2_reg <= m2_reg >> 1;
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg > v_reg)
            begin
                u_reg <= (u_reg - v_reg) >> 1;
            end
            else
            begin
                v_reg <= (v_reg - u_reg) >> 1;
            end
        end
        else if (cmd.div_init)
        begin
            rem1_reg <= '0;
            rem2_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            m1_reg   <= {m1_reg[PW-2:0], ge1};
            m2_reg   <= {m2_reg[PW-2:0], ge2};
            rem1_reg <= ge1 ? d1[PW-1:0] : t1[PW-1:0];
            rem2_reg <= ge2 ? d2[PW-1:0] : t2[PW-1:0];
        end
        if (cmd.res_load)
        begin
            res_num_reg  <= rn_x[rau_pkg::RES_W-1:0];
            res_den_reg  <= rd_x[rau_pkg::RES_W-1:0];
            zero_den_reg <= (rd_x[rau_pkg::RES_W-1:0] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            cnt_reg <= CW'(PW);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_comb
    begin
        xe   = XW'(x_reg);
        ye   = XW'(y_reg);
        ze   = XW'(z_reg);
        ane  = XW'(an_reg);
        ade  = XW'(ad_reg);
        q1e  = XW'(m1_reg);
        q2e  = XW'(m2_reg);
        rn_x = ane;
        rd_x = ade;
        if (cmd.res_quot)
        begin
            rn_x = x_reg[PW-1] ? -q1e : q1e;
            rd_x = y_reg[PW-1] ? -q2e : q2e;
        end
        else
        begin
            case (op_reg)
                rau_pkg::OP_ADD:
                begin
                    rn_x = xe + ye;
                    rd_x = ze;
                end
                rau_pkg::OP_SUB:
                begin
                    rn_x = xe - ye;
                    rd_x = ze;
                end
                rau_pkg::OP_MUL, rau_pkg::OP_DIV:
                begin
                    rn_x = xe;
                    rd_x = ye;
                end
                rau_pkg::OP_INC:
                begin
                    rn_x = ane + ade;
                    rd_x = ade;
                end
                rau_pkg::OP_DEC:
                begin
                    rn_x = ane - ade;
                    rd_x = ade;
                end
                default:
                begin
                    rn_x = ane;
                    rd_x = ade;
                end
            endcase
        end
    end

    assign status.is_mul   = is_mul;
    assign status.gcd_zero = (x_reg == '0) || (y_reg == '0);
    assign status.gcd_done = (u_reg == v_reg);
    assign status.div_done = (cnt_reg == '0);

    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign zero_den = zero_den_reg;

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcd_step |-> (u_reg != '0) && (v_reg != '0))
        else $error("GCD operand reached zero.");

    a_exact_division: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && cmd.res_quot) |-> (rem1_reg == '0) && (rem2_reg == '0))
        else $error("Reduction by the GCD left a remainder.");

endmodule

// ----- tb/rau_result_checker.sv -----
`timescale 1ns / 1ps

module rau_result_checker (
    input  logic  clk,
    input  logic  rst_n,
    rau_in_if     operands,
    rau_out_if    result,
    output int    errors,
    output int    outstanding
);

    typedef struct packed {
        logic [rau_pkg::RES_W-1:0] num;
        logic [rau_pkg::RES_W-1:0] den;
        logic                      zero;
    } fraction_t;

    fraction_t pending_fractions[$];

    function automatic fraction_t fraction_result(
        input logic [2:0]         code,
        input logic signed [15:0] an,
        input logic signed [15:0] ad,
        input logic signed [15:0] bn,
        input logic signed [15:0] bd
    );
        longint          san;
        longint          sad;
        longint          sbn;
        longint          sbd;
        longint          rn;
        longint          rd;
        longint          prod_num;
        longint          prod_den;
        longint unsigned mag_num;
        longint unsigned mag_den;
        longint unsigned g;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        fraction_t       f;

        san = an;
        sad = ad;
        sbn = bn;
        sbd = bd;
        case (code)
            rau_pkg::OP_ADD:
            begin
                rn = san * sbd + sad * sbn;
                rd = sad * sbd;
            end
            rau_pkg::OP_SUB:
            begin
                rn = san * sbd - sad * sbn;
                rd = sad * sbd;
            end
            rau_pkg::OP_MUL:
            begin
                prod_num = san * sbn;
                prod_den = sad * sbd;
                mag_num  = (prod_num < 0) ? longint'(-prod_num) : longint'(prod_num);
                mag_den  = (prod_den < 0) ? longint'(-prod_den) : longint'(prod_den);
                g = 1;
                if (mag_num != 0 && mag_den != 0)
                begin
                    x = mag_num;
                    y = mag_den;
                    while (y != 0)
                    begin
                        t = x % y;
                        x = y;
                        y = t;
                    end
                    g = x;
                end
                mag_num = mag_num / g;
                mag_den = mag_den / g;
                rn = (prod_num < 0) ? -longint'(mag_num) : longint'(mag_num);
                rd = (prod_den < 0) ? -longint'(mag_den) : longint'(mag_den);
            end
            rau_pkg::OP_DIV:
            begin
                rn = san * sbd;
                rd = sad * sbn;
            end
            rau_pkg::OP_INC:
            begin
                rn = san + sad;
                rd = sad;
            end
            rau_pkg::OP_DEC:
            begin
                rn = san - sad;
                rd = sad;
            end
            default:
            begin
                rn = san;
                rd = sad;
            end
        endcase
        f.num  = rn[rau_pkg::RES_W-1:0];
        f.den  = rd[rau_pkg::RES_W-1:0];
        f.zero = (f.den == '0);
        return f;
    endfunction

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        fraction_t exp_f;

        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (pending_fractions.size() == 0)
                begin
                    $display("%0t: unexpected result transfer: num %0d den %0d zero_den %0b",
                             $time, result.res_num, result.res_den, result.zero_den);
                    errors = errors + 1;
                end
                else
                begin
                    exp_f = pending_fractions.pop_front();
                    if (result.res_num !== exp_f.num)
                    begin
                        $display("%0t: res_num mismatch: expected %0d, actual %0d",
                                 $time, $signed(exp_f.num), result.res_num);
                        errors = errors + 1;
                    end
                    if (result.res_den !== exp_f.den)
                    begin
                        $display("%0t: res_den mismatch: expected %0d, actual %0d",
                                 $time, $signed(exp_f.den), result.res_den);
                        errors = errors + 1;
                    end
                    if (result.zero_den !== exp_f.zero)
                    begin
                        $display("%0t: zero_den mismatch: expected %0b, actual %0b",
                                 $time, exp_f.zero, result.zero_den);
                        errors = errors + 1;
                    end
                end
            end
            if (operands.valid && operands.ready)
            begin
                pending_fractions.push_back(fraction_result(operands.op, operands.a_num,
                                                            operands.a_den, operands.b_num,
                                                            operands.b_den));
            end
            outstanding = pending_fractions.size();
        end
    end

endmodule

// ----- tb/rational_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;

    localparam int                 OPW        = 16;
    localparam int                 RAND_ITEMS = 1650;
    localparam logic [2:0]         OP_RSVD6   = 3'd6;
    localparam logic [2:0]         OP_RSVD7   = 3'd7;
    localparam logic signed [15:0] S_MIN      = 16'sh8000;
    localparam logic signed [15:0] S_MAX      = 16'sh7fff;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    bit   steady;

    rau_in_if #(.OPERAND_WIDTH(OPW)) operands ();
    rau_out_if                       result ();

    rational_arithmetic_unit #(
        .OPERAND_WIDTH(OPW)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .result   (result)
    );

    rau_result_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .operands    (operands),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(30, 150);
    endfunction

    function automatic logic signed [15:0] pick_operand();
        int r;

        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 4))
                0:       return S_MIN;
                1:       return S_MAX;
                2:       return 16'sd0;
                3:       return 16'sd1;
                default: return -16'sd1;
            endcase
        end
        else if (r < 4)
            return 16'($signed($urandom_range(0, 24)) - 12);
        else
            return 16'($urandom);
    endfunction

    task automatic drive_operands(
        input logic [2:0]         code,
        input logic signed [15:0] an,
        input logic signed [15:0] ad,
        input logic signed [15:0] bn,
        input logic signed [15:0] bd
    );
        int gap;

        gap = pick_gap();
        if (gap > 0)
        begin
            operands.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operands.valid = 1'b1;
        operands.op    = code;
        operands.a_num = an;
        operands.a_den = ad;
        operands.b_num = bn;
        operands.b_den = bd;
        @(posedge clk);
        while (!operands.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int hold;
        int r;

        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (steady || r < 60)
                hold = 0;
            else if (r < 95)
                hold = $urandom_range(1, 3);
            else
                hold = $urandom_range(20, 80);
            result.ready = 1'b0;
            repeat (hold) @(negedge clk);
            result.ready = 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
    end

    initial
    begin
        logic [2:0] code;

        steady         = 1'b0;
        rst_n          = 1'b0;
        operands.valid = 1'b0;
        operands.op    = rau_pkg::OP_ADD;
        operands.a_num = '0;
        operands.a_den = '0;
        operands.b_num = '0;
        operands.b_den = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        drive_operands(rau_pkg::OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        drive_operands(rau_pkg::OP_ADD, S_MIN, S_MIN, S_MIN, S_MIN);
        drive_operands(rau_pkg::OP_ADD, S_MAX, S_MAX, S_MAX, S_MAX);
        drive_operands(rau_pkg::OP_ADD, 16'sd5, 16'sd0, 16'sd3, 16'sd7);
        drive_operands(rau_pkg::OP_SUB, S_MIN, S_MIN, S_MAX, S_MAX);
        drive_operands(rau_pkg::OP_SUB, S_MAX, S_MIN, S_MIN, S_MAX);
        drive_operands(rau_pkg::OP_SUB, -16'sd1, 16'sd4, 16'sd1, -16'sd4);
        drive_operands(rau_pkg::OP_MUL, 16'sd6, 16'sd4, 16'sd2, 16'sd9);
        drive_operands(rau_pkg::OP_MUL, S_MAX, S_MAX, S_MAX, S_MAX);
        drive_operands(rau_pkg::OP_MUL, S_MIN, S_MIN, S_MIN, S_MIN);
        drive_operands(rau_pkg::OP_MUL, S_MIN, S_MAX, S_MAX, S_MIN);
        drive_operands(rau_pkg::OP_MUL, 16'sd0, 16'sd6, 16'sd4, 16'sd8);
        drive_operands(rau_pkg::OP_MUL, 16'sd6, 16'sd0, 16'sd4, 16'sd8);
        drive_operands(rau_pkg::OP_MUL, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        drive_operands(rau_pkg::OP_MUL, -16'sd12, 16'sd18, 16'sd30, -16'sd45);
        drive_operands(rau_pkg::OP_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5);
        drive_operands(rau_pkg::OP_DIV, S_MIN, S_MAX, S_MAX, S_MIN);
        drive_operands(rau_pkg::OP_DIV, S_MIN, S_MIN, S_MIN, S_MIN);
        drive_operands(rau_pkg::OP_INC, S_MAX, S_MAX, S_MIN, S_MIN);
        drive_operands(rau_pkg::OP_INC, S_MIN, S_MIN, 16'sd0, 16'sd0);
        drive_operands(rau_pkg::OP_INC, 16'sd3, 16'sd0, S_MAX, S_MAX);
        drive_operands(rau_pkg::OP_DEC, S_MIN, S_MAX, S_MAX, S_MAX);
        drive_operands(rau_pkg::OP_DEC, S_MAX, S_MIN, 16'sd1, 16'sd1);
        drive_operands(OP_RSVD6, S_MIN, S_MAX, 16'sd7, 16'sd9);
        drive_operands(OP_RSVD7, S_MAX, 16'sd0, S_MIN, S_MIN);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 150 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
                code = ($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7;
            else
                code = 3'($urandom_range(rau_pkg::OP_ADD, rau_pkg::OP_DEC));
            drive_operands(code, pick_operand(), pick_operand(), pick_operand(),
                           pick_operand());
        end
        operands.valid = 1'b0;
        steady = 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/rau_pkg.sv
hdl/rau_if.sv
hdl/rau_ctrl.sv
hdl/rau_datapath.sv
hdl/rational_arithmetic_unit.sv
tb/rau_result_checker.sv
tb/rational_arithmetic_unit_tb.sv
